FILE: hw/rtl/rmeu_pkg.sv
// ----------------------------------------------------------------------------
// rmeu_pkg
// Types and codes shared by the register machine execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
package rmeu_pkg;

  localparam int OP_W = 4;
  localparam int MODE_W = 2;
  localparam int IN_W = 32;
  localparam int TGT_W = 8;
  localparam int ST_W = 3;
  localparam int PC_W = 9;

  typedef enum logic [3:0] {
    OP_LOAD  = 4'd0,
    OP_STORE = 4'd1,
    OP_ADD   = 4'd2,
    OP_SUB   = 4'd3,
    OP_MUL   = 4'd4,
    OP_DIV   = 4'd5,
    OP_READ  = 4'd6,
    OP_WRITE = 4'd7,
    OP_JUMP  = 4'd8,
    OP_JZERO = 4'd9,
    OP_JGTZ  = 4'd10,
    OP_HALT  = 4'd11
  } op_t;

  localparam logic [1:0] MODE_CONST = 2'd0;
  localparam logic [1:0] MODE_DIRECT = 2'd1;
  localparam logic [1:0] MODE_INDIRECT = 2'd2;
  localparam logic [1:0] MODE_INVALID = 2'd3;

  localparam logic [2:0] ST_OK = 3'd0;
  localparam logic [2:0] ST_HALT = 3'd1;
  localparam logic [2:0] ST_CONST = 3'd2;
  localparam logic [2:0] ST_LABEL = 3'd3;
  localparam logic [2:0] ST_INVALID = 3'd4;
  localparam logic [2:0] ST_DIVZERO = 3'd5;
  localparam logic [2:0] ST_RANGE = 3'd6;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLEAR,
    S_RD1,
    S_RD1W,
    S_RD2,
    S_RD2W,
    S_EXEC,
    S_MUL,
    S_DIV,
    S_DIVFIX,
    S_DONE
  } state_t;

  typedef enum logic [1:0] {
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } alu_sts_t;

endpackage
`default_nettype wire

FILE: hw/rtl/rmeu_if.sv
// ----------------------------------------------------------------------------
// rmeu_if
// Valid/ready channels of the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none
interface rmeu_in_if;
  logic        valid;
  logic        ready;
  logic [3:0]  operation;
  logic [1:0]  address_mode;
  logic signed [31:0] operand_value;
  logic        label_found;
  logic [7:0]  jump_target;
  logic signed [31:0] input_value;
  modport source (output valid, operation, address_mode, operand_value, label_found,
                  jump_target, input_value, input ready);
  modport sink (input valid, operation, address_mode, operand_value, label_found,
                jump_target, input_value, output ready);
endinterface

interface rmeu_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [8:0]  next_pc;
  logic        output_valid;
  logic signed [31:0] output_value;
  logic        stopped;
  logic signed [31:0] accumulator_value;
  modport source (output valid, status, next_pc, output_valid, output_value, stopped,
                  accumulator_value, input ready);
  modport sink (input valid, status, next_pc, output_valid, output_value, stopped,
                accumulator_value, output ready);
endinterface

interface rmeu_cfg_if;
  logic       valid;
  logic       ready;
  logic [8:0] data;
  modport source (output valid, data, input ready);
  modport sink (input valid, data, output ready);
endinterface
`default_nettype wire

FILE: hw/rtl/rmeu_alu.sv
// ----------------------------------------------------------------------------
// rmeu_alu
// Bit-serial multiplier and restoring divider (magnitudes, sign fixed after).
// ----------------------------------------------------------------------------
`default_nettype none
module rmeu_alu #(
  parameter int WORD_WIDTH = 32
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire rmeu_pkg::alu_ctl_t    ctl,
  input  wire logic [WORD_WIDTH-1:0] a,
  input  wire logic [WORD_WIDTH-1:0] b,
  output rmeu_pkg::alu_sts_t         sts,
  output logic [WORD_WIDTH-1:0]      result
);
  localparam int CW = $clog2(WORD_WIDTH + 1);

  logic [CW-1:0] count;
  logic busy;
  rmeu_pkg::alu_op_t op;
  logic [WORD_WIDTH-1:0] acc;   // product or remainder
  logic [WORD_WIDTH-1:0] sh;    // multiplier bits or dividend/quotient
  logic [WORD_WIDTH-1:0] dv;    // multiplicand or divisor magnitude
  logic neg;
  logic done;
  logic [WORD_WIDTH:0] trial;

  assign trial = {acc, sh[WORD_WIDTH-1]} - {1'b0, dv};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        count <= CW'(WORD_WIDTH);
        op <= ctl.op;
        acc <= '0;
        if (ctl.op == rmeu_pkg::ALU_MUL) begin
          sh <= b;
          dv <= a;
        end else begin
          sh <= a[WORD_WIDTH-1] ? -a : a;
          dv <= b[WORD_WIDTH-1] ? -b : b;
          neg <= a[WORD_WIDTH-1] ^ b[WORD_WIDTH-1];
        end
      end else if (busy) begin
        if (op == rmeu_pkg::ALU_MUL) begin
          // shift-left form: acc = acc*2 + a when top multiplier bit set
          acc <= (acc << 1) + (sh[WORD_WIDTH-1] ? dv : '0);
          sh <= sh << 1;
        end else begin
          if (!trial[WORD_WIDTH]) begin
            acc <= trial[WORD_WIDTH-1:0];
            sh <= {sh[WORD_WIDTH-2:0], 1'b1};
          end else begin
            acc <= {acc[WORD_WIDTH-2:0], sh[WORD_WIDTH-1]};
            sh <= {sh[WORD_WIDTH-2:0], 1'b0};
          end
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_comb begin
    if (op == rmeu_pkg::ALU_MUL) result = acc;
    else result = neg ? -sh : sh;
  end

  assign sts.busy = busy;
  assign sts.done = done;
endmodule
`default_nettype wire

FILE: hw/rtl/ram_machine_execute_unit_core.sv
// ----------------------------------------------------------------------------
// ram_machine_execute_unit_core
// Execute unit of a random access machine: register file, pc, serial ALU.
// ----------------------------------------------------------------------------
// One decoded instruction is taken on in_ch; one result request leaves on
// out_ch. The unit works on one instruction at a time: in_ch.ready is high
// only while idle. From acceptance the unit steps through S_RD1, S_RD1W and
// S_EXEC to S_DONE with a constant or direct operand; an indirect one with an
// in-range register number adds S_RD2 and, for an in-range pointer, S_RD2W,
// for the extra register file read. MUL and DIV go from S_EXEC through S_MUL
// or S_DIV, one bit per cycle in the shift loop, and S_DIVFIX. The next
// instruction is taken at the earliest in the cycle after the result leaves.
// The result sits in an output register until out_ch.ready; a stalled receiver holds the unit in that state.
// cfg_ch writes program_length (saturated to PROG_DEPTH) and is always ready.
// After reset a clearing pass zeroes the register file, one word a cycle;
// no instruction is accepted during it. The program counter resets to zero
// and program_length to min(PROG_DEPTH, 256).
// ----------------------------------------------------------------------------
`default_nettype none
module ram_machine_execute_unit_core #(
  parameter int DATA_DEPTH = 64,
  parameter int PROG_DEPTH = 256,
  parameter int WORD_WIDTH = 32
) (
  input wire logic clk,
  input wire logic rst,
  rmeu_in_if.sink    in_ch,
  rmeu_out_if.source out_ch,
  rmeu_cfg_if.sink   cfg_ch
);
  localparam int AW = (DATA_DEPTH > 1) ? $clog2(DATA_DEPTH) : 1;
  localparam int OW = 32;
  localparam int PL_RESET = (PROG_DEPTH < 256) ? PROG_DEPTH : 256;
  // a 9-bit length can never exceed 511
  localparam int PL_SAT = (PROG_DEPTH < 511) ? PROG_DEPTH : 511;

  rmeu_pkg::state_t state, state_next;
  logic [WORD_WIDTH-1:0] mem [DATA_DEPTH];
  logic [WORD_WIDTH-1:0] rdata;
  logic [AW-1:0] raddr;
  logic re;
  logic we;
  logic [AW-1:0] waddr;
  logic [WORD_WIDTH-1:0] wdata;
  logic [AW:0] clr;
  logic [8:0] pc;
  logic [8:0] plen;

  logic [3:0] op;
  logic [1:0] mode;
  logic signed [31:0] opnd;
  logic found;
  logic [7:0] tgt;
  logic [WORD_WIDTH-1:0] inval;
  logic [WORD_WIDTH-1:0] acc;
  logic [WORD_WIDTH-1:0] val;
  logic [AW-1:0] addr;

  logic [2:0] r_status;
  logic [8:0] r_npc;
  logic r_ovalid;
  logic [WORD_WIDTH-1:0] r_oval;

  rmeu_pkg::alu_ctl_t alu_ctl;
  rmeu_pkg::alu_sts_t alu_sts;
  logic [WORD_WIDTH-1:0] alu_res;

  rmeu_alu #(.WORD_WIDTH(WORD_WIDTH)) u_alu (
    .clk(clk), .rst(rst), .ctl(alu_ctl), .a(acc), .b(val), .sts(alu_sts),
    .result(alu_res)
  );

  // register-number range checks
  logic opnd_ok;
  logic rd_ok;
  assign opnd_ok = !opnd[31] && (33'(unsigned'(opnd)) < 33'(DATA_DEPTH));
  assign rd_ok = !rdata[WORD_WIDTH-1] &&
                 ((WORD_WIDTH+1)'(rdata) < (WORD_WIDTH+1)'(DATA_DEPTH));

  logic [OW-1:0] opnd_w;
  assign opnd_w = opnd;
  logic [WORD_WIDTH-1:0] opnd_x;
  always_comb begin
    if (WORD_WIDTH <= 32) opnd_x = opnd_w[WORD_WIDTH-1:0];
    else opnd_x = WORD_WIDTH'(signed'(opnd));
  end

  logic acc_zero, acc_pos;
  assign acc_zero = (acc == '0);
  assign acc_pos = !acc[WORD_WIDTH-1] && !acc_zero;

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    if (re) rdata <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) state <= rmeu_pkg::S_CLEAR;
    else state <= state_next;
  end

  assign in_ch.ready = (state == rmeu_pkg::S_IDLE);
  assign cfg_ch.ready = 1'b1;
  assign out_ch.valid = (state == rmeu_pkg::S_DONE);

  always_comb begin
    state_next = state;
    re = 1'b0;
    raddr = '0;
    alu_ctl.start = 1'b0;
    alu_ctl.op = rmeu_pkg::ALU_MUL;
    case (state)
      rmeu_pkg::S_CLEAR: begin
        if (clr == (AW+1)'(DATA_DEPTH - 1)) state_next = rmeu_pkg::S_IDLE;
      end
      rmeu_pkg::S_IDLE: begin
        if (in_ch.valid) state_next = rmeu_pkg::S_RD1;
      end
      rmeu_pkg::S_RD1: begin
        re = 1'b1;
        raddr = opnd_w[AW-1:0];
        state_next = rmeu_pkg::S_RD1W;
      end
      rmeu_pkg::S_RD1W: begin
        if (mode == rmeu_pkg::MODE_INDIRECT && opnd_ok) state_next = rmeu_pkg::S_RD2;
        else state_next = rmeu_pkg::S_EXEC;
      end
      rmeu_pkg::S_RD2: begin
        re = 1'b1;
        raddr = AW'(rdata);
        state_next = rd_ok ? rmeu_pkg::S_RD2W : rmeu_pkg::S_EXEC;
      end
      rmeu_pkg::S_RD2W: state_next = rmeu_pkg::S_EXEC;
      rmeu_pkg::S_EXEC: begin
        state_next = rmeu_pkg::S_DONE;
        if (r_status == rmeu_pkg::ST_OK && pc < plen && op == rmeu_pkg::OP_MUL) begin
          alu_ctl.start = 1'b1;
          state_next = rmeu_pkg::S_MUL;
        end else if (r_status == rmeu_pkg::ST_OK && pc < plen && op == rmeu_pkg::OP_DIV &&
                     val != '0) begin
          alu_ctl.start = 1'b1;
          alu_ctl.op = rmeu_pkg::ALU_DIV;
          state_next = rmeu_pkg::S_DIV;
        end
      end
      rmeu_pkg::S_MUL, rmeu_pkg::S_DIV: begin
        alu_ctl.op = (state == rmeu_pkg::S_DIV) ? rmeu_pkg::ALU_DIV : rmeu_pkg::ALU_MUL;
        if (alu_sts.done) state_next = rmeu_pkg::S_DIVFIX;
      end
      rmeu_pkg::S_DIVFIX: state_next = rmeu_pkg::S_DONE;
      rmeu_pkg::S_DONE: begin
        if (out_ch.ready) state_next = rmeu_pkg::S_IDLE;
      end
      default: state_next = rmeu_pkg::S_IDLE;
    endcase
  end

  // Write port, status decision and accumulator shadow
  always_ff @(posedge clk) begin
    we <= 1'b0;
    if (rst) begin
      clr <= '0;
      pc <= '0;
      plen <= 9'(PL_RESET);
      acc <= '0;
    end else begin
      if (cfg_ch.valid) begin
        plen <= (cfg_ch.data > 9'(PL_SAT)) ? 9'(PL_SAT) : cfg_ch.data;
      end
      case (state)
        rmeu_pkg::S_CLEAR: begin
          we <= 1'b1;
          waddr <= clr[AW-1:0];
          wdata <= '0;
          clr <= clr + 1'b1;
        end
        rmeu_pkg::S_IDLE: begin
          op <= in_ch.operation;
          mode <= in_ch.address_mode;
          opnd <= in_ch.operand_value;
          found <= in_ch.label_found;
          tgt <= in_ch.jump_target;
          inval <= WORD_WIDTH'(signed'(in_ch.input_value));
        end
        // pre-status set while operands are fetched
        rmeu_pkg::S_RD1: begin
          if (op <= rmeu_pkg::OP_WRITE && mode == rmeu_pkg::MODE_INVALID)
            r_status <= rmeu_pkg::ST_INVALID;
          else if (op <= rmeu_pkg::OP_WRITE && mode == rmeu_pkg::MODE_CONST &&
                   (op == rmeu_pkg::OP_STORE || op == rmeu_pkg::OP_READ))
            r_status <= rmeu_pkg::ST_CONST;
          else if (op <= rmeu_pkg::OP_WRITE && mode != rmeu_pkg::MODE_CONST && !opnd_ok)
            r_status <= rmeu_pkg::ST_RANGE;
          else r_status <= rmeu_pkg::ST_OK;
        end
        rmeu_pkg::S_RD1W: begin
          addr <= opnd_w[AW-1:0];
          if (mode == rmeu_pkg::MODE_CONST) val <= opnd_x;
          else val <= rdata;
        end
        rmeu_pkg::S_RD2: begin
          addr <= AW'(rdata);
          if (!rd_ok && r_status == rmeu_pkg::ST_OK && op <= rmeu_pkg::OP_WRITE)
            r_status <= rmeu_pkg::ST_RANGE;
        end
        rmeu_pkg::S_RD2W: val <= rdata;
        rmeu_pkg::S_EXEC: begin
          r_ovalid <= 1'b0;
          r_oval <= '0;
          r_npc <= pc;
          if (pc >= plen) begin
            r_status <= rmeu_pkg::ST_OK;
          end else if (op > rmeu_pkg::OP_HALT) begin
            r_status <= rmeu_pkg::ST_INVALID;
          end else if (op == rmeu_pkg::OP_HALT) begin
            r_status <= rmeu_pkg::ST_HALT;
          end else if (op >= rmeu_pkg::OP_JUMP) begin
            if (!(op == rmeu_pkg::OP_JUMP || (op == rmeu_pkg::OP_JZERO && acc_zero) ||
                  (op == rmeu_pkg::OP_JGTZ && acc_pos))) begin
              r_status <= rmeu_pkg::ST_OK;
              r_npc <= pc + 1'b1;
            end else if (!found) begin
              r_status <= rmeu_pkg::ST_LABEL;
            end else begin
              r_status <= rmeu_pkg::ST_OK;
              r_npc <= {1'b0, tgt};
            end
          end else if (r_status != rmeu_pkg::ST_OK) begin
            // invalid mode, constant or range error already decided
          end else if (op == rmeu_pkg::OP_DIV && val == '0) begin
            r_status <= rmeu_pkg::ST_DIVZERO;
          end else begin
            r_npc <= pc + 1'b1;
            case (op)
              rmeu_pkg::OP_LOAD: begin
                we <= 1'b1; waddr <= '0; wdata <= val; acc <= val;
              end
              rmeu_pkg::OP_STORE: begin
                we <= 1'b1; waddr <= addr; wdata <= acc;
                if (addr == '0) acc <= acc;
              end
              rmeu_pkg::OP_ADD: begin
                we <= 1'b1; waddr <= '0; wdata <= acc + val; acc <= acc + val;
              end
              rmeu_pkg::OP_SUB: begin
                we <= 1'b1; waddr <= '0; wdata <= acc - val; acc <= acc - val;
              end
              rmeu_pkg::OP_READ: begin
                we <= 1'b1; waddr <= addr; wdata <= inval;
                if (addr == '0) acc <= inval;
              end
              rmeu_pkg::OP_WRITE: begin
                r_ovalid <= 1'b1; r_oval <= val;
              end
              default: ;
            endcase
          end
        end
        rmeu_pkg::S_DIVFIX: begin
          we <= 1'b1;
          waddr <= '0;
          wdata <= alu_res;
          acc <= alu_res;
        end
        rmeu_pkg::S_DONE: begin
          if (out_ch.ready) pc <= r_npc;
        end
        default: ;
      endcase
    end
  end

  assign out_ch.status = r_status;
  assign out_ch.next_pc = r_npc;
  assign out_ch.output_valid = r_ovalid;
  assign out_ch.output_value = 32'(signed'(r_oval));
  assign out_ch.stopped = (r_status != rmeu_pkg::ST_OK) || (r_npc >= plen);
  assign out_ch.accumulator_value = 32'(signed'(acc));
endmodule
`default_nettype wire

FILE: hw/rtl/rmeu_checker.sv
// ----------------------------------------------------------------------------
// rmeu_checker
// Port-level checks of the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module rmeu_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       in_valid,
  input wire logic       in_ready,
  input wire logic       out_valid,
  input wire logic       out_ready,
  input wire logic [2:0] status,
  input wire logic       stopped,
  input wire logic       output_valid
);
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid)) else $error("input taken while result pending");
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    in_valid && in_ready |=> !in_ready) else $error("second request taken while busy");
  a_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(status))
    else $error("result dropped");
  a_err_stops: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rmeu_pkg::ST_OK |-> stopped) else $error("error without stop");
  a_err_no_out: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != rmeu_pkg::ST_OK |-> !output_valid)
    else $error("output on error");
endmodule

bind ram_machine_execute_unit_core rmeu_checker u_chk (
  .clk(clk), .rst(rst), .in_valid(in_ch.valid), .in_ready(in_ch.ready),
  .out_valid(out_ch.valid), .out_ready(out_ch.ready), .status(out_ch.status),
  .stopped(out_ch.stopped), .output_valid(out_ch.output_valid)
);
`default_nettype wire
